### rtl/point_cloud_raster_plotter_unit_macros.svh
// Assertion macros for the point cloud raster plotter.
// Used by the top level; no other dependencies.
`ifndef POINT_CLOUD_RASTER_PLOTTER_UNIT_MACROS_SVH
`define POINT_CLOUD_RASTER_PLOTTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PCRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define PCRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pcrp_pkg.sv
// Shared types and constants for the point cloud raster plotter.
// No dependencies; the RTL modules refer to it by scoped names and the testbench imports it.
package pcrp_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int CFG_W  = 9;
    localparam int DIM_W  = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
    localparam int A_W    = 17;
    localparam int B_W    = ((DIM_W > 8) ? DIM_W : 8) + 1;
    localparam int P_W    = A_W + B_W;
    localparam int T_W    = P_W + 1;
    localparam int N_W    = T_W + 1;
    localparam int D_W    = 18;
    localparam int CNT_W  = $clog2(N_W + 1);
    localparam int CI_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RI_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PIX_MAX = 255;

    // Configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_SCAN  = 2'd1,
        OP_PLOT  = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SEL_COL = 2'd0,
        SEL_ROW = 2'd1,
        SEL_VAL = 2'd2
    } t_sel;

    typedef struct packed {
        t_op                opcode;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic [15:0]        intensity;
        logic [7:0]         read_row;
        logic [7:0]         read_col;
    } t_in;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       plotted;
        logic [7:0] plot_col;
        logic [7:0] plot_row;
        logic       scale_error;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic clr_start;
        logic clr_step;
        logic scan;
        logic prep;
        logic div_start;
        logic take;
        logic fin;
        logic rd;
        logic rd_out;
        logic res_zero;
        logic res_err;
        t_sel sel;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic scale_zero;
    } t_stat;

endpackage

### rtl/point_cloud_raster_plotter_unit.sv
// Point cloud raster plotter top level. Plots use the shared one-bit-per-cycle divider;
// a clear zeroes one store entry per cycle. One item at a time.
// Reset is synchronous, active low; after reset the store is swept with busy high.
// Results are strobed on o_done for one cycle and the receiver cannot stall.
// Depends on pcrp_pkg, pcrp_ctrl, pcrp_datapath and the macros header.
`include "point_cloud_raster_plotter_unit_macros.svh"

module point_cloud_raster_plotter_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  pcrp_pkg::t_in               i_in,
    output logic                        o_busy,
    output logic                        o_done,
    output pcrp_pkg::t_out              o_result,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [pcrp_pkg::CFG_W-1:0]  i_cfg_data
);

    pcrp_pkg::t_cmd  cmd;
    pcrp_pkg::t_stat stat;

    pcrp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_opcode (i_in.opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_done   (o_done)
    );

    pcrp_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_result   (o_result)
    );

    // Checks
    `PCRP_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy || o_done, "accepted item left block idle without result")
    `PCRP_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done, !o_busy, "result strobed while busy")
    `PCRP_ASSERT_NOW(a_plot_no_err, i_clk, i_rst_n, o_done && o_result.plotted, !o_result.scale_error, "plotted point flagged with scale error")

endmodule

### rtl/pcrp_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pcrp_pkg for operand widths.
module pcrp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pcrp_pkg::N_W-1:0]   i_num,
    input  logic [pcrp_pkg::D_W-1:0]   i_den,
    output logic                       o_done,
    output logic [pcrp_pkg::N_W-1:0]   o_quo
);

    logic [pcrp_pkg::D_W-1:0]   r_rem;
    logic [pcrp_pkg::N_W-1:0]   r_quo;
    logic [pcrp_pkg::D_W-1:0]   r_den;
    logic [pcrp_pkg::CNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [pcrp_pkg::D_W:0]     n_trial;
    logic                       n_fit;

    // Shift in the next dividend bit and try the subtraction
    assign n_trial = {r_rem, r_quo[pcrp_pkg::N_W-1]};
    assign n_fit   = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= pcrp_pkg::CNT_W'(pcrp_pkg::N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - pcrp_pkg::CNT_W'(1);
                if (r_cnt == pcrp_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_fit ? pcrp_pkg::D_W'(n_trial - {1'b0, r_den})
                           : pcrp_pkg::D_W'(n_trial);
            r_quo <= {r_quo[pcrp_pkg::N_W-2:0], n_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### rtl/pcrp_datapath.sv
// Datapath: config, maxima, scaling products, divider, pixel store, result register.
// Depends on pcrp_pkg and pcrp_div.
module pcrp_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pcrp_pkg::t_in                  i_in,
    input  pcrp_pkg::t_cmd                 i_cmd,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [pcrp_pkg::CFG_W-1:0]     i_cfg_data,
    output pcrp_pkg::t_stat                o_stat,
    output pcrp_pkg::t_out                 o_result
);

    logic [pcrp_pkg::CFG_W-1:0]     r_cfg_w, r_cfg_h;
    logic [pcrp_pkg::DIM_W-1:0]     w_eff, h_eff;
    pcrp_pkg::t_in                  r_in;
    logic [15:0]                    r_lx, r_ly, r_li;
    logic signed [pcrp_pkg::P_W-1:0] r_pa, r_pb;
    logic signed [pcrp_pkg::A_W-1:0] a1, a2;
    logic signed [pcrp_pkg::B_W-1:0] b1, b2;
    logic signed [pcrp_pkg::P_W-1:0] m1, m2, n_pb;
    logic signed [pcrp_pkg::T_W-1:0] t_sum;
    logic [pcrp_pkg::T_W-1:0]       t_mag;
    logic [pcrp_pkg::D_W-1:0]       den_rnd, div_den;
    logic [pcrp_pkg::N_W-1:0]       div_num, quo;
    logic                           div_done;
    logic                           r_tneg, r_neg_col, r_neg_row;
    logic [pcrp_pkg::N_W-1:0]       r_q_col, r_q_row, r_q_val;
    logic                           col_ok, row_ok, hit;
    logic [7:0]                     val;
    logic [pcrp_pkg::ADDR_W-1:0]    r_clr_addr, wr_addr, rd_addr;
    logic [7:0]                     r_mem [0:pcrp_pkg::DEPTH-1];
    logic [7:0]                     r_rd_data;
    logic                           r_rd_ok, rd_ok;
    pcrp_pkg::t_out                 r_res, n_res;

    // Effective image size, saturated at the store size
    assign w_eff = (r_cfg_w > pcrp_pkg::MAX_WIDTH) ? pcrp_pkg::DIM_W'(pcrp_pkg::MAX_WIDTH)
                                                   : pcrp_pkg::DIM_W'(r_cfg_w);
    assign h_eff = (r_cfg_h > pcrp_pkg::MAX_HEIGHT) ? pcrp_pkg::DIM_W'(pcrp_pkg::MAX_HEIGHT)
                                                    : pcrp_pkg::DIM_W'(r_cfg_h);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= pcrp_pkg::CFG_W'(256);
            r_cfg_h <= pcrp_pkg::CFG_W'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcrp_pkg::CFG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                pcrp_pkg::CFG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                default:                    r_cfg_w <= r_cfg_w;
            endcase
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in;
        end
    end

    // Running maxima; clear zeroes them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_start) begin
            r_lx <= '0;
            r_ly <= '0;
            r_li <= '0;
        end else if (i_cmd.scan) begin
            if (i_in.x_coord > $signed(r_lx)) r_lx <= i_in.x_coord;
            if (i_in.y_coord > $signed(r_ly)) r_ly <= i_in.y_coord;
            if (i_in.intensity > r_li)        r_li <= i_in.intensity;
        end
    end

    assign o_stat.scale_zero = (r_lx == '0) || (r_ly == '0) || (r_li == '0);

    // Scaling products for the selected division
    always_comb begin
        a1   = '0;
        b1   = '0;
        a2   = '0;
        b2   = '0;
        unique case (i_cmd.sel)
            pcrp_pkg::SEL_COL: begin
                a1 = pcrp_pkg::A_W'(r_in.x_coord);
                b1 = $signed(pcrp_pkg::B_W'(w_eff));
                a2 = $signed({1'b0, r_lx});
                b2 = $signed(pcrp_pkg::B_W'(w_eff >> 1));
            end
            pcrp_pkg::SEL_ROW: begin
                a1 = $signed({1'b0, r_ly});
                b1 = $signed(pcrp_pkg::B_W'(h_eff));
                a2 = pcrp_pkg::A_W'(r_in.y_coord);
                b2 = $signed(pcrp_pkg::B_W'(h_eff));
            end
            pcrp_pkg::SEL_VAL: begin
                a1 = $signed({1'b0, r_in.intensity});
                b1 = $signed(pcrp_pkg::B_W'(pcrp_pkg::PIX_MAX));
            end
            default: begin
                a1 = '0;
            end
        endcase
        m1 = pcrp_pkg::P_W'(a1) * pcrp_pkg::P_W'(b1);
        m2 = pcrp_pkg::P_W'(a2) * pcrp_pkg::P_W'(b2);
        unique case (i_cmd.sel)
            pcrp_pkg::SEL_COL: n_pb = m2 <<< 1;
            pcrp_pkg::SEL_ROW: n_pb = -m2;
            default:           n_pb = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_pa <= m1;
            r_pb <= n_pb;
        end
    end

    // Rounded numerator and divisor for the selected division
    always_comb begin
        t_sum = pcrp_pkg::T_W'(r_pa) + pcrp_pkg::T_W'(r_pb);
        t_mag = t_sum[pcrp_pkg::T_W-1] ? pcrp_pkg::T_W'(-t_sum) : pcrp_pkg::T_W'(t_sum);
        unique case (i_cmd.sel)
            pcrp_pkg::SEL_COL: begin
                den_rnd = pcrp_pkg::D_W'({r_lx, 1'b0});
                div_den = pcrp_pkg::D_W'({r_lx, 2'b00});
            end
            pcrp_pkg::SEL_ROW: begin
                den_rnd = pcrp_pkg::D_W'(r_ly);
                div_den = pcrp_pkg::D_W'({r_ly, 1'b0});
            end
            default: begin
                den_rnd = '0;
                div_den = pcrp_pkg::D_W'(r_li);
            end
        endcase
        div_num = (i_cmd.sel == pcrp_pkg::SEL_VAL) ? pcrp_pkg::N_W'(t_mag)
                  : pcrp_pkg::N_W'({t_mag, 1'b0}) + pcrp_pkg::N_W'(den_rnd);
    end

    pcrp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign o_stat.div_done = div_done;

    // Hold sign and quotients
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_tneg <= t_sum[pcrp_pkg::T_W-1];
        end
        if (i_cmd.take) begin
            unique case (i_cmd.sel)
                pcrp_pkg::SEL_COL: begin
                    r_q_col   <= quo;
                    r_neg_col <= r_tneg;
                end
                pcrp_pkg::SEL_ROW: begin
                    r_q_row   <= quo;
                    r_neg_row <= r_tneg;
                end
                default: begin
                    r_q_val <= quo;
                end
            endcase
        end
    end

    // Range check; a negative result only survives when it rounds to zero
    assign col_ok = !(r_neg_col && (r_q_col != '0)) && (r_q_col < pcrp_pkg::N_W'(w_eff));
    assign row_ok = !(r_neg_row && (r_q_row != '0)) && (r_q_row < pcrp_pkg::N_W'(h_eff));
    assign hit    = col_ok && row_ok;
    assign val    = (r_q_val > pcrp_pkg::N_W'(pcrp_pkg::PIX_MAX)) ? 8'(pcrp_pkg::PIX_MAX)
                                                                  : r_q_val[7:0];

    // Clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_start) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + pcrp_pkg::ADDR_W'(1);
        end
    end

    assign o_stat.clr_last = r_clr_addr == pcrp_pkg::ADDR_W'(pcrp_pkg::DEPTH - 1);

    // Store addresses
    assign wr_addr = i_cmd.clr_step ? r_clr_addr
        : pcrp_pkg::ADDR_W'(int'(r_q_row[pcrp_pkg::RI_W-1:0]) * pcrp_pkg::MAX_WIDTH
                            + int'(r_q_col[pcrp_pkg::CI_W-1:0]));
    assign rd_ok   = (int'(r_in.read_row) < pcrp_pkg::MAX_HEIGHT)
                  && (int'(r_in.read_col) < pcrp_pkg::MAX_WIDTH);
    assign rd_addr = rd_ok ? pcrp_pkg::ADDR_W'(int'(r_in.read_row) * pcrp_pkg::MAX_WIDTH
                                               + int'(r_in.read_col))
                           : '0;

    // Pixel store
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[wr_addr] <= '0;
        end else if (i_cmd.fin && hit) begin
            r_mem[wr_addr] <= val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_ok   <= rd_ok;
        end
    end

    // Next result: unused fields stay zero
    always_comb begin
        n_res = '0;
        if (i_cmd.res_zero) begin
            n_res = '0;
        end else if (i_cmd.res_err) begin
            n_res.scale_error = 1'b1;
        end else if (i_cmd.fin) begin
            if (hit) begin
                n_res.pixel_value = val;
                n_res.plotted     = 1'b1;
                n_res.plot_col    = r_q_col[7:0];
                n_res.plot_row    = r_q_row[7:0];
            end
        end else if (i_cmd.rd_out) begin
            n_res.pixel_value = r_rd_ok ? r_rd_data : 8'd0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_zero || i_cmd.res_err || i_cmd.fin || i_cmd.rd_out) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule

### rtl/pcrp_ctrl.sv
// Controller state machine: sequences clear sweep, scans, plots and reads.
// Depends on pcrp_pkg.
module pcrp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  pcrp_pkg::t_op    i_opcode,
    input  pcrp_pkg::t_stat  i_stat,
    output pcrp_pkg::t_cmd   o_cmd,
    output logic             o_busy,
    output logic             o_done
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_PREP  = 8'b0000_0100,
        S_START = 8'b0000_1000,
        S_WAIT  = 8'b0001_0000,
        S_FIN   = 8'b0010_0000,
        S_READ  = 8'b0100_0000,
        S_RDOUT = 8'b1000_0000
    } t_state;

    t_state          r_state, n_state;
    pcrp_pkg::t_sel  r_sel, n_sel;
    logic            r_clr_item, n_clr_item;
    logic            r_done, n_done;
    pcrp_pkg::t_cmd  cmd;

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        n_clr_item = r_clr_item;
        n_done     = 1'b0;
        cmd        = '0;
        cmd.sel    = r_sel;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                    if (r_clr_item) begin
                        cmd.res_zero = 1'b1;
                        n_done       = 1'b1;
                    end
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    cmd.accept = 1'b1;
                    unique case (i_opcode)
                        pcrp_pkg::OP_CLEAR: begin
                            cmd.clr_start = 1'b1;
                            n_clr_item    = 1'b1;
                            n_state       = S_CLEAR;
                        end
                        pcrp_pkg::OP_SCAN: begin
                            cmd.scan     = 1'b1;
                            cmd.res_zero = 1'b1;
                            n_done       = 1'b1;
                        end
                        pcrp_pkg::OP_PLOT: begin
                            if (i_stat.scale_zero) begin
                                cmd.res_err = 1'b1;
                                n_done      = 1'b1;
                            end else begin
                                n_sel   = pcrp_pkg::SEL_COL;
                                n_state = S_PREP;
                            end
                        end
                        pcrp_pkg::OP_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                n_state  = S_START;
            end
            S_START: begin
                cmd.div_start = 1'b1;
                n_state       = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.div_done) begin
                    cmd.take = 1'b1;
                    unique case (r_sel)
                        pcrp_pkg::SEL_COL: begin
                            n_sel   = pcrp_pkg::SEL_ROW;
                            n_state = S_PREP;
                        end
                        pcrp_pkg::SEL_ROW: begin
                            n_sel   = pcrp_pkg::SEL_VAL;
                            n_state = S_PREP;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_FIN: begin
                cmd.fin = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_READ: begin
                cmd.rd  = 1'b1;
                n_state = S_RDOUT;
            end
            S_RDOUT: begin
                cmd.rd_out = 1'b1;
                n_done     = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Reset starts with a sweep of the pixel store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_sel      <= pcrp_pkg::SEL_COL;
            r_clr_item <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sel      <= n_sel;
            r_clr_item <= (n_state == S_CLEAR) ? n_clr_item : 1'b0;
            r_done     <= n_done;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_state != S_IDLE;
    assign o_done = r_done;

endmodule

### tb/tb_point_cloud_raster_plotter_unit.sv
// Testbench for the point cloud raster plotter: directed and random command streams,
// checked against a behavioral image model. Depends on pcrp_pkg and the top-level RTL.
module tb_point_cloud_raster_plotter_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import pcrp_pkg::*;

    // Behavioral image model and store of pending pixel results
    class raster_scoreboard;
        int          top_x, top_y, top_int;
        int          width_reg, height_reg;
        byte unsigned image[MAX_WIDTH*MAX_HEIGHT];
        t_out        pending[$];
        int          errors;

        function new();
            width_reg  = 256;
            height_reg = 256;
            wipe();
        endfunction

        function void wipe();
            top_x = 0;
            top_y = 0;
            top_int = 0;
            foreach (image[i]) image[i] = 0;
        endfunction

        function void write_reg(logic idx, int val);
            if (idx == CFG_IMAGE_WIDTH) width_reg = val;
            else height_reg = val;
        endfunction

        // round(num/den), half away from zero, den > 0
        function longint round_div(longint num, longint den);
            if (num >= 0) return (2*num + den) / (2*den);
            return -((-2*num + den) / (2*den));
        endfunction

        // Note an accepted command transfer and queue its result
        function void note_cmd(t_in c);
            t_out   r;
            longint w, h, col, row, den;
            int     val;
            r = '0;
            case (c.opcode)
                OP_CLEAR: wipe();
                OP_SCAN: begin
                    if (int'(c.x_coord) > top_x) top_x = c.x_coord;
                    if (int'(c.y_coord) > top_y) top_y = c.y_coord;
                    if (int'(c.intensity) > top_int) top_int = c.intensity;
                end
                OP_PLOT: begin
                    w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
                    h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
                    if (top_x == 0 || top_y == 0 || top_int == 0) begin
                        r.scale_error = 1'b1;
                    end else begin
                        den = 2 * longint'(top_x);
                        col = round_div(longint'(c.x_coord) * w + (w / 2) * den, den);
                        den = top_y;
                        row = round_div(h * den - longint'(c.y_coord) * h, den);
                        if (col >= 0 && col < w && row >= 0 && row < h) begin
                            val = int'(c.intensity) * 255 / top_int;
                            if (val > 255) val = 255;
                            image[row*MAX_WIDTH + col] = val;
                            r.pixel_value = val;
                            r.plotted     = 1'b1;
                            r.plot_col    = col[7:0];
                            r.plot_row    = row[7:0];
                        end
                    end
                end
                default: begin
                    if (c.read_row < MAX_HEIGHT && c.read_col < MAX_WIDTH)
                        r.pixel_value = image[c.read_row*MAX_WIDTH + c.read_col];
                end
            endcase
            pending.push_back(r);
        endfunction

        // Compare a result transfer with the oldest pending one
        function void check_result(t_out got);
            t_out e;
            if (pending.size() == 0) begin
                $error("result with nothing pending: %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.pixel_value !== e.pixel_value) begin
                $error("pixel_value exp %0d got %0d", e.pixel_value, got.pixel_value);
                errors++;
            end
            if (got.plotted !== e.plotted) begin
                $error("plotted exp %0d got %0d", e.plotted, got.plotted);
                errors++;
            end
            if (got.plot_col !== e.plot_col) begin
                $error("plot_col exp %0d got %0d", e.plot_col, got.plot_col);
                errors++;
            end
            if (got.plot_row !== e.plot_row) begin
                $error("plot_row exp %0d got %0d", e.plot_row, got.plot_row);
                errors++;
            end
            if (got.scale_error !== e.scale_error) begin
                $error("scale_error exp %0d got %0d", e.scale_error, got.scale_error);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    t_in              i_in;
    logic             o_busy;
    logic             o_done;
    t_out             o_result;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    raster_scoreboard sb = new();
    int               gap_max;

    point_cloud_raster_plotter_unit u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Check every result strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_result);
    end

    // Issue one command and hold it until the transfer; call at a falling edge
    task automatic send_cmd(t_in c);
        i_start = 1'b1;
        i_in    = c;
        do @(posedge i_clk); while (o_busy);
        sb.note_cmd(c);
        @(negedge i_clk);
        i_start = 1'b0;
        if (gap_max > 0 && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
    endtask

    function automatic t_in make_cmd(t_op op, int x, int y, int inten, int row, int col);
        t_in c;
        c.opcode    = op;
        c.x_coord   = x[15:0];
        c.y_coord   = y[15:0];
        c.intensity = inten[15:0];
        c.read_row  = row[7:0];
        c.read_col  = col[7:0];
        return c;
    endfunction

    // Write a size register once every pending result has drained
    task automatic write_size(logic idx, int val);
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.write_reg(idx, val);
    endtask

    function automatic int pick_size(int k);
        case (k % 6)
            0: return 256;
            1: return 1;
            2: return 511;
            3: return 0;
            4: return $urandom_range(2, 16);
            default: return $urandom_range(1, 256);
        endcase
    endfunction

    // Random point within the current maxima, with some spill past them
    function automatic t_in make_point(t_op op);
        int mx, my;
        mx = (sb.top_x > 0) ? sb.top_x : 256;
        my = (sb.top_y > 0) ? sb.top_y : 256;
        mx = mx + mx / 8;
        my = my + my / 8;
        if (mx > 32767) mx = 32767;
        if (my > 32767) my = 32767;
        return make_cmd(op, $urandom_range(0, 2*mx) - mx, $urandom_range(0, my) - my / 10,
                        $urandom_range(0, (sb.top_int > 0) ? sb.top_int + 200 : 65535),
                        0, 0);
    endfunction

    initial begin
        t_in c;
        int  n_pts;
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_IMAGE_WIDTH;
        i_cfg_data = '0;
        gap_max    = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero maxima, negative scans, edges of the image, saturation
        send_cmd(make_cmd(OP_PLOT, 100, 100, 100, 0, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_SCAN, -5, -5, 0, 0, 0));
        send_cmd(make_cmd(OP_PLOT, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_SCAN, 256, 256, 1000, 0, 0));
        send_cmd(make_cmd(OP_PLOT, 0, 0, 1000, 0, 0));
        send_cmd(make_cmd(OP_PLOT, 0, 256, 500, 0, 0));
        send_cmd(make_cmd(OP_PLOT, 256, 128, 700, 0, 0));
        send_cmd(make_cmd(OP_PLOT, -256, 128, 65535, 0, 0));
        send_cmd(make_cmd(OP_PLOT, 255, 1, 999, 0, 0));
        send_cmd(make_cmd(OP_PLOT, -32768, -32768, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 128, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 128));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 255, 255));
        send_cmd(make_cmd(OP_SCAN, 32767, 32767, 65535, 0, 0));
        send_cmd(make_cmd(OP_PLOT, 32767, 1, 65535, 0, 0));
        send_cmd(make_cmd(OP_PLOT, -32767, 32767, 1, 0, 0));
        send_cmd(make_cmd(OP_CLEAR, -1, -1, 65535, 255, 255));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 128));

        // Random phases: sizes, optional clear, scans, plots, reads and noise
        for (int ph = 0; ph < 10; ph++) begin
            write_size(CFG_IMAGE_WIDTH, pick_size(ph));
            write_size(CFG_IMAGE_HEIGHT, pick_size(ph + 3));
            gap_max = (ph >= 8 || $urandom_range(0, 3) == 0) ? 0 : 16;
            if (ph % 2 == 1)
                send_cmd(make_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                  $urandom));
            n_pts = $urandom_range(2, 6);
            for (int k = 0; k < n_pts; k++) begin
                c = make_cmd(OP_SCAN, $urandom_range(1, (ph < 3) ? 32767 : 2048),
                             $urandom_range(1, (ph < 3) ? 32767 : 2048),
                             $urandom_range(1, 65535), $urandom, $urandom);
                send_cmd(c);
            end
            for (int k = 0; k < 34; k++) begin
                case ($urandom_range(0, 9))
                    0: send_cmd(make_cmd(t_op'($urandom_range(1, 3)), $urandom, $urandom,
                                         $urandom, $urandom, $urandom));
                    1, 2: send_cmd(make_cmd(OP_READ, $urandom, $urandom, $urandom,
                                            $urandom_range(0, 255), $urandom_range(0, 255)));
                    3: begin
                        c = make_point(OP_PLOT);
                        c.read_row = $urandom;
                        c.read_col = $urandom;
                        send_cmd(c);
                        send_cmd(make_cmd(OP_READ, 0, 0, 0, sb.pending[$].plot_row,
                                          sb.pending[$].plot_col));
                    end
                    default: send_cmd(make_point(OP_PLOT));
                endcase
            end
        end

        // Drain, then let the tail settle
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
